>>> hw/rtl/csm_pkg.sv
// csm_pkg: widths, register map, record types and count helpers for the clip site merger.
// No dependencies; every other file of the block but csm_checker imports it.
package csm_pkg;

   localparam int CHROM_W = 5;
   localparam int POS_W   = 31;
   localparam int CNT_W   = 24;
   localparam int CFG_W   = 16;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int NRES    = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_REACH   = 2'd1;
   localparam logic [1:0] REG_SUPPORT = 2'd2;

   localparam logic [CFG_W-1:0] WINDOW_RST  = 16'd100;
   localparam logic [CFG_W-1:0] REACH_RST   = 16'd2000;
   localparam logic [CFG_W-1:0] SUPPORT_RST = 16'd2;

   typedef struct packed {
      logic [CFG_W-1:0] merge_window;
      logic [CFG_W-1:0] discordant_reach;
      logic [CFG_W-1:0] min_support;
   } cfg_type;

   typedef struct packed {
      logic [CHROM_W-1:0] site_chrom;
      logic [POS_W-1:0]   site_pos;
      logic [CNT_W-1:0]   start_clips;
      logic [CNT_W-1:0]   end_clips;
      logic [CNT_W-1:0]   discordants;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic [CHROM_W-1:0] out_chrom;
      logic [POS_W-1:0]   out_pos;
      logic [CNT_W-1:0]   out_start;
      logic [CNT_W-1:0]   out_end;
      logic [CNT_W-1:0]   out_disc;
      logic               passes;
      logic               final_out;
   } result_type;

   // up to three results from one request, slot order = emit order
   typedef struct packed {
      logic [NRES-1:0]             mask;
      result_type [NRES-1:0]       slot;
   } bundle_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] pos_gap(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic result_type make_result(input logic [CHROM_W-1:0] chrom,
                                              input logic [POS_W-1:0]   pos,
                                              input logic [CNT_W-1:0]   st,
                                              input logic [CNT_W-1:0]   en,
                                              input logic [CNT_W-1:0]   di,
                                              input logic [CFG_W-1:0]   support,
                                              input logic               fin);
      result_type r;
      logic [CNT_W:0] both;
      both        = {1'b0, st} + {1'b0, en};
      r.out_chrom = chrom;
      r.out_pos   = pos;
      r.out_start = st;
      r.out_end   = en;
      r.out_disc  = di;
      r.passes    = (both >= (CNT_W+1)'(support));
      r.final_out = fin;
      return r;
   endfunction

endpackage

>>> hw/rtl/csm_req_if.sv
// csm_req_if: request channel, valid/ready plus one clip site.
// Depends on csm_pkg for field widths.
interface csm_req_if;
   import csm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHROM_W-1:0] site_chrom;
   logic [POS_W-1:0]   site_pos;
   logic [CNT_W-1:0]   start_clips;
   logic [CNT_W-1:0]   end_clips;
   logic [CNT_W-1:0]   discordants;
   logic               last_item;

   modport source (output valid, site_chrom, site_pos, start_clips, end_clips, discordants,
                   last_item, input ready);
   modport sink   (input valid, site_chrom, site_pos, start_clips, end_clips, discordants,
                   last_item, output ready);
endinterface

>>> hw/rtl/csm_rsp_if.sv
// csm_rsp_if: result channel, valid/ready plus one merged site.
// Depends on csm_pkg for field widths.
interface csm_rsp_if;
   import csm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CHROM_W-1:0] out_chrom;
   logic [POS_W-1:0]   out_pos;
   logic [CNT_W-1:0]   out_start;
   logic [CNT_W-1:0]   out_end;
   logic [CNT_W-1:0]   out_disc;
   logic               passes;
   logic               final_out;

   modport source (output valid, out_chrom, out_pos, out_start, out_end, out_disc, passes,
                   final_out, input ready);
   modport sink   (input valid, out_chrom, out_pos, out_start, out_end, out_disc, passes,
                   final_out, output ready);
endinterface

>>> hw/rtl/csm_csr.sv
// csm_csr: APB-style register file for window, reach and minimum support.
// Depends on csm_pkg.
module csm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [csm_pkg::ADDR_W-1:0]  paddr,
   input  logic [csm_pkg::DATA_W-1:0]  pwdata,
   output logic [csm_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output csm_pkg::cfg_type            cfg
);
   import csm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[3:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WINDOW:  cfg_in.merge_window     = pwdata[CFG_W-1:0];
            REG_REACH:   cfg_in.discordant_reach = pwdata[CFG_W-1:0];
            REG_SUPPORT: cfg_in.min_support      = pwdata[CFG_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_WINDOW:  prdata = DATA_W'(cfg_ff.merge_window);
         REG_REACH:   prdata = DATA_W'(cfg_ff.discordant_reach);
         REG_SUPPORT: prdata = DATA_W'(cfg_ff.min_support);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.merge_window     <= WINDOW_RST;
         cfg_ff.discordant_reach <= REACH_RST;
         cfg_ff.min_support      <= SUPPORT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/csm_core.sv
// csm_core: input register, held/pending site state and the one-pass merge decision.
// Depends on csm_pkg and csm_req_if; hands result bundles to csm_out.
module csm_core (
   input  logic                  clock,
   input  logic                  reset,
   csm_req_if.sink               req,
   input  csm_pkg::cfg_type      cfg,
   input  logic                  bundle_free,
   output csm_pkg::bundle_type   bundle,
   output logic                  bundle_load
);
   import csm_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // held site
   logic [CHROM_W-1:0] held_chrom_ff, held_chrom_in;
   logic [POS_W-1:0]   held_pos_ff, held_pos_in;
   logic [CNT_W-1:0]   held_start_ff, held_start_in;
   logic [CNT_W-1:0]   held_end_ff, held_end_in;
   logic [CNT_W-1:0]   held_disc_ff, held_disc_in;
   logic               held_valid_ff, held_valid_in;

   // pending discordant-only site
   logic [CHROM_W-1:0] wait_chrom_ff, wait_chrom_in;
   logic [POS_W-1:0]   wait_pos_ff, wait_pos_in;
   logic [CNT_W-1:0]   wait_start_ff, wait_start_in;
   logic [CNT_W-1:0]   wait_end_ff, wait_end_in;
   logic [CNT_W-1:0]   wait_disc_ff, wait_disc_in;
   logic               wait_valid_ff, wait_valid_in;

   logic [CNT_W-1:0]   d;
   logic [POS_W-1:0]   dh, dn, dl;
   logic [POS_W-1:0]   reach;
   logic signed [POS_W:0] fold_diff;
   logic               advance;
   bundle_type         bnd;

   assign reach = POS_W'(cfg.discordant_reach);

   always_comb begin
      held_chrom_in = held_chrom_ff;
      held_pos_in   = held_pos_ff;
      held_start_in = held_start_ff;
      held_end_in   = held_end_ff;
      held_disc_in  = held_disc_ff;
      held_valid_in = held_valid_ff;
      wait_chrom_in = wait_chrom_ff;
      wait_pos_in   = wait_pos_ff;
      wait_start_in = wait_start_ff;
      wait_end_in   = wait_end_ff;
      wait_disc_in  = wait_disc_ff;
      wait_valid_in = wait_valid_ff;
      d       = in_item_ff.discordants;
      bnd     = '0;
      dh      = pos_gap(wait_pos_ff, held_pos_ff);
      dn      = pos_gap(wait_pos_ff, in_item_ff.site_pos);

      // resolve the pending discordant-only site against held vs. this site
      if (wait_valid_ff) begin
         if (!held_valid_ff) begin
            held_chrom_in = wait_chrom_ff; held_pos_in = wait_pos_ff;
            held_start_in = wait_start_ff; held_end_in = wait_end_ff;
            held_disc_in  = wait_disc_ff;  held_valid_in = 1'b1;
         end else if (dn < dh) begin
            if (dn < reach) begin
               d = sat_add(d, wait_disc_ff);
            end else begin
               bnd.mask[0] = 1'b1;
               bnd.slot[0] = make_result(held_chrom_ff, held_pos_ff, held_start_ff,
                                         held_end_ff, held_disc_ff, cfg.min_support, 1'b0);
               held_chrom_in = wait_chrom_ff; held_pos_in = wait_pos_ff;
               held_start_in = wait_start_ff; held_end_in = wait_end_ff;
               held_disc_in  = wait_disc_ff;
            end
         end else if (dh < reach) begin
            held_disc_in = sat_add(held_disc_ff, wait_disc_ff);
         end else begin
            bnd.mask[0] = 1'b1;
            bnd.slot[0] = make_result(held_chrom_ff, held_pos_ff, held_start_ff,
                                      held_end_ff, held_disc_ff, cfg.min_support, 1'b0);
            held_chrom_in = wait_chrom_ff; held_pos_in = wait_pos_ff;
            held_start_in = wait_start_ff; held_end_in = wait_end_ff;
            held_disc_in  = wait_disc_ff;
         end
         wait_valid_in = 1'b0;
      end

      dl        = pos_gap(in_item_ff.site_pos, held_pos_in);
      fold_diff = $signed({1'b0, in_item_ff.site_pos}) - $signed({1'b0, held_pos_in});

      // place this site
      if (!held_valid_in) begin
         held_chrom_in = in_item_ff.site_chrom; held_pos_in = in_item_ff.site_pos;
         held_start_in = in_item_ff.start_clips; held_end_in = in_item_ff.end_clips;
         held_disc_in  = d; held_valid_in = 1'b1;
      end else if (in_item_ff.start_clips == '0 && in_item_ff.end_clips == '0 && d != '0) begin
         if (!in_item_ff.last_item) begin
            wait_chrom_in = in_item_ff.site_chrom; wait_pos_in = in_item_ff.site_pos;
            wait_start_in = in_item_ff.start_clips; wait_end_in = in_item_ff.end_clips;
            wait_disc_in  = d; wait_valid_in = 1'b1;
         end else if (dl < reach) begin
            held_disc_in = sat_add(held_disc_in, d);
         end else begin
            bnd.mask[1] = 1'b1;
            bnd.slot[1] = make_result(held_chrom_in, held_pos_in, held_start_in,
                                      held_end_in, held_disc_in, cfg.min_support, 1'b0);
            held_chrom_in = in_item_ff.site_chrom; held_pos_in = in_item_ff.site_pos;
            held_start_in = in_item_ff.start_clips; held_end_in = in_item_ff.end_clips;
            held_disc_in  = d;
         end
      end else if (in_item_ff.site_chrom == held_chrom_in &&
                   fold_diff <= $signed({{(POS_W-CFG_W+1){1'b0}}, cfg.merge_window})) begin
         held_start_in = sat_add(held_start_in, in_item_ff.start_clips);
         held_end_in   = sat_add(held_end_in, in_item_ff.end_clips);
         held_disc_in  = sat_add(held_disc_in, d);
      end else begin
         bnd.mask[1] = 1'b1;
         bnd.slot[1] = make_result(held_chrom_in, held_pos_in, held_start_in,
                                   held_end_in, held_disc_in, cfg.min_support, 1'b0);
         held_chrom_in = in_item_ff.site_chrom; held_pos_in = in_item_ff.site_pos;
         held_start_in = in_item_ff.start_clips; held_end_in = in_item_ff.end_clips;
         held_disc_in  = d;
      end

      // end of set: flush held site
      if (in_item_ff.last_item) begin
         bnd.mask[2] = 1'b1;
         bnd.slot[2] = make_result(held_chrom_in, held_pos_in, held_start_in,
                                   held_end_in, held_disc_in, cfg.min_support, 1'b1);
         held_valid_in = 1'b0;
         wait_valid_in = 1'b0;
      end
   end

   // a request with no result never waits on the output side
   assign advance     = in_valid_ff & ((bnd.mask == '0) | bundle_free);
   assign bundle      = bnd;
   assign bundle_load = advance & (bnd.mask != '0);
   assign req.ready   = ~in_valid_ff | advance;
   assign in_valid_in = req.valid | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         wait_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            held_valid_ff <= held_valid_in;
            wait_valid_ff <= wait_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_item_ff.site_chrom  <= req.site_chrom;
         in_item_ff.site_pos    <= req.site_pos;
         in_item_ff.start_clips <= req.start_clips;
         in_item_ff.end_clips   <= req.end_clips;
         in_item_ff.discordants <= req.discordants;
         in_item_ff.last_item   <= req.last_item;
      end
      if (advance) begin
         held_chrom_ff <= held_chrom_in; held_pos_ff  <= held_pos_in;
         held_start_ff <= held_start_in; held_end_ff  <= held_end_in;
         held_disc_ff  <= held_disc_in;
         wait_chrom_ff <= wait_chrom_in; wait_pos_ff  <= wait_pos_in;
         wait_start_ff <= wait_start_in; wait_end_ff  <= wait_end_in;
         wait_disc_ff  <= wait_disc_in;
      end
   end

endmodule

>>> hw/rtl/csm_out.sv
// csm_out: result register holding one bundle of up to three results, sent one per cycle while the sink is ready.
// Depends on csm_pkg and csm_rsp_if; fed by csm_core.
module csm_out (
   input  logic                 clock,
   input  logic                 reset,
   input  csm_pkg::bundle_type  bundle,
   input  logic                 bundle_load,
   output logic                 bundle_free,
   csm_rsp_if.source            rsp
);
   import csm_pkg::*;

   logic [NRES-1:0]       mask_ff, mask_in;
   result_type [NRES-1:0] slot_ff;
   logic [NRES-1:0]       sel;
   logic [NRES-1:0]       left;
   result_type            cur;
   logic                  pop;

   // oldest pending slot first
   always_comb begin
      sel = '0;
      cur = slot_ff[0];
      if (mask_ff[0]) begin
         sel[0] = 1'b1;
      end else if (mask_ff[1]) begin
         sel[1] = 1'b1;
         cur    = slot_ff[1];
      end else begin
         sel[2] = mask_ff[2];
         cur    = slot_ff[2];
      end
   end

   assign pop         = rsp.valid & rsp.ready;
   assign left        = mask_ff & ~(pop ? sel : '0);
   assign bundle_free = (left == '0);
   assign mask_in     = bundle_load ? bundle.mask : left;

   assign rsp.valid     = |mask_ff;
   assign rsp.out_chrom = cur.out_chrom;
   assign rsp.out_pos   = cur.out_pos;
   assign rsp.out_start = cur.out_start;
   assign rsp.out_end   = cur.out_end;
   assign rsp.out_disc  = cur.out_disc;
   assign rsp.passes    = cur.passes;
   assign rsp.final_out = cur.final_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule

>>> hw/rtl/clip_site_merger_unit.sv
// clip_site_merger_unit: merges sorted clip sites into candidate sites; top level.
// Path: an accepted request sits in the input register, where csm_core decides it; its
//   results are then loaded into the result register and offered from there.
// Throughput: 1 request per cycle while each gives at most one result and results are taken;
//   one with more results holds the result register; they drain one per cycle when taken.
// Reset: synchronous, active high; clears the input, held/pending and result valid flags;
//   registers return to window 100, reach 2000, minimum support 2.
module clip_site_merger_unit (
   input  logic                        clock,
   input  logic                        reset,
   csm_req_if.sink                     req_chan,
   csm_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [csm_pkg::ADDR_W-1:0]  paddr,
   input  logic [csm_pkg::DATA_W-1:0]  pwdata,
   output logic [csm_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import csm_pkg::*;

   cfg_type    cfg;
   bundle_type bundle;
   logic       bundle_load;
   logic       bundle_free;

   // config registers; the user must write them only while the block is idle (not enforced here)
   csm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // request register + merge state; one request decided per cycle while the result register has room
   csm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .cfg         (cfg),
      .bundle_free (bundle_free),
      .bundle      (bundle),
      .bundle_load (bundle_load)
   );

   // result register; drains a bundle in emit order
   csm_out u_out (
      .clock       (clock),
      .reset       (reset),
      .bundle      (bundle),
      .bundle_load (bundle_load),
      .bundle_free (bundle_free),
      .rsp         (rsp_chan)
   );

endmodule

>>> hw/rtl/csm_checker.sv
// csm_checker: port-level checks on the merger top level, plus its bind.
// Depends on clip_site_merger_unit.
module csm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_pos,
   input logic        rsp_final
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos) && $stable(rsp_final))
      else $error("result changed while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // with no result pending the request side never stalls
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind clip_site_merger_unit csm_checker u_csm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pos   (rsp_chan.out_pos),
   .rsp_final (rsp_chan.final_out)
);
